// ----- design/ffs_pkg.sv -----
// Package for the forest fire stencil step core.
// Shared types, field widths and register indexes; no dependencies.
package ffs_pkg;

  localparam int STATE_W    = 2;
  localparam int ROLL_W     = 8;
  localparam int GW_W       = 7;
  localparam int GH_W       = 13;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 13;
  localparam int COL_OUT_W  = 6;
  localparam int ROW_OUT_W  = 12;
  localparam int MATCH_W    = 18;
  localparam int NBR_CNT    = 8;
  localparam int NBR_CNT_W  = 4;
  localparam int MIN_DIM    = 3;

  localparam int S_TDATA_W  = 24;
  localparam int M_TDATA_W  = 40;

  localparam int DEF_MAX_WIDTH  = 64;
  localparam int DEF_MAX_HEIGHT = 4096;

  localparam logic [GW_W-1:0]    GRID_WIDTH_RST    = GW_W'(64);
  localparam logic [GH_W-1:0]    GRID_HEIGHT_RST   = GH_W'(64);
  localparam logic [STATE_W-1:0] COUNTED_STATE_RST = STATE_W'(1);

  localparam logic [CFG_IDX_W-1:0] REG_GRID_WIDTH    = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_GRID_HEIGHT   = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] REG_COUNTED_STATE = CFG_IDX_W'(2);

  typedef enum logic [STATE_W-1:0] {
    ST_HEALTHY = 2'd0,
    ST_BURNING = 2'd1,
    ST_BURNT   = 2'd2,
    ST_INVALID = 2'd3
  } cell_state_t;

endpackage

// ----- design/ffs_line_store.sv -----
// Upper and middle line stores of the stencil, one entry per column.
// Registered read at request time, write-back when the item leaves stage B.
module ffs_line_store #(
  parameter int DEPTH  = ffs_pkg::DEF_MAX_WIDTH,
  parameter int ADDR_W = $clog2(ffs_pkg::DEF_MAX_WIDTH)
) (
  input  logic                        clk,
  input  logic                        rd_en,
  input  logic [ADDR_W-1:0]           rd_addr,
  output logic [ffs_pkg::STATE_W-1:0] rd_upper,
  output logic [ffs_pkg::STATE_W-1:0] rd_middle,
  input  logic                        wr_en,
  input  logic [ADDR_W-1:0]           wr_addr,
  input  logic [ffs_pkg::STATE_W-1:0] wr_upper,
  input  logic [ffs_pkg::STATE_W-1:0] wr_middle
);
  import ffs_pkg::*;

  logic [STATE_W-1:0] upper_mem  [DEPTH];
  logic [STATE_W-1:0] middle_mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      upper_mem[wr_addr]  <= wr_upper;
      middle_mem[wr_addr] <= wr_middle;
    end
    if (rd_en) begin
      rd_upper  <= upper_mem[rd_addr];
      rd_middle <= middle_mem[rd_addr];
    end
  end

endmodule

// ----- design/ffs_cell_rule.sv -----
// Next-state rule for one interior cell from its 3x3 neighborhood.
// Uses ffs_pkg for the cell state encoding.
module ffs_cell_rule (
  input  ffs_pkg::cell_state_t          center,
  input  ffs_pkg::cell_state_t          nbrs [ffs_pkg::NBR_CNT],
  input  logic [ffs_pkg::ROLL_W-1:0]    ignite_roll,
  input  logic [ffs_pkg::ROLL_W-1:0]    burnout_roll,
  output ffs_pkg::cell_state_t          new_state
);
  import ffs_pkg::*;

  logic [NBR_CNT_W-1:0] burning_cnt;

  always_comb begin
    burning_cnt = '0;
    for (int i = 0; i < NBR_CNT; i++) begin
      burning_cnt = burning_cnt + NBR_CNT_W'(nbrs[i] == ST_BURNING);
    end
  end

  always_comb begin
    new_state = center;
    case (center)
      ST_HEALTHY: begin
        if (ignite_roll < ROLL_W'(burning_cnt)) new_state = ST_BURNING;
      end
      ST_BURNING: begin
        if (burnout_roll == '0) new_state = ST_BURNT;
      end
      default: new_state = center;
    endcase
  end

endmodule

// ----- design/forest_fire_stencil_step_core.sv -----
// Forest fire generation step as a streaming 3x3 stencil with line stores.
// Depends on ffs_pkg, ffs_line_store and ffs_cell_rule.
//
// Usage: cells of one generation enter on s_axis in raster order, one request
// per cell (state plus ignite and burnout rolls for the cell emitted now).
// Interior cells leave on m_axis with their next state, column, row and the
// running count of results equal to counted_state; tlast marks the final
// interior cell of the generation. Border cells produce no result.
// Path: the request that completes a window is read from the line store at
// acceptance, then the rule result is loaded into the output register.
// Throughput: one cell per cycle unless m_axis stalls; the line store has one
// read and one write port, so each column is read and written once per cell.
// Stalls: the output register holds a result while m_axis_tready is low; a
// cell still enters if the working stage is empty, otherwise s_axis_tready
// drops until the result is taken. Border cells never wait on m_axis.
// Reset: counters, window and config go to defaults (64 x 64, count state 1).
// Writing grid_width or grid_height restarts the frame; write config only
// while the block is idle. Line stores are not cleared.
module forest_fire_stencil_step_core #(
  parameter int MAX_WIDTH  = ffs_pkg::DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = ffs_pkg::DEF_MAX_HEIGHT
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_we,
  input  logic [ffs_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [ffs_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  // cell_state[1:0], ignite_roll[9:2], burnout_roll[17:10], zero pad
  input  logic [ffs_pkg::S_TDATA_W-1:0]  s_axis_tdata,
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  // new_state[1:0], cell_column[7:2], cell_row[19:8], matching_total[37:20], pad
  output logic [ffs_pkg::M_TDATA_W-1:0]  m_axis_tdata,
  // last_of_frame
  output logic                           m_axis_tlast
);
  import ffs_pkg::*;

  localparam int COL_W   = (MAX_WIDTH > 2) ? $clog2(MAX_WIDTH) : 1;
  localparam int ROW_W   = (MAX_HEIGHT > 2) ? $clog2(MAX_HEIGHT) : 1;
  localparam int WEFF_W  = $clog2(MAX_WIDTH + 1);
  localparam int HEFF_W  = $clog2(MAX_HEIGHT + 1);
  localparam int WCMP_W  = (GW_W > WEFF_W) ? GW_W : WEFF_W;
  localparam int HCMP_W  = (GH_W > HEFF_W) ? GH_W : HEFF_W;

  // configuration
  logic [GW_W-1:0]    grid_width;
  logic [GH_W-1:0]    grid_height;
  logic [STATE_W-1:0] counted_state;

  // scan position
  logic [COL_W-1:0]   col;
  logic [ROW_W-1:0]   row;
  logic [COL_W-1:0]   col_last;
  logic [ROW_W-1:0]   row_last;
  logic [WCMP_W-1:0]  gw_ext;
  logic [HCMP_W-1:0]  gh_ext;
  logic [WCMP_W-1:0]  w_eff;
  logic [HCMP_W-1:0]  h_eff;

  // stage B
  logic               b_valid;
  cell_state_t        b_cur;
  logic [ROLL_W-1:0]  b_iroll;
  logic [ROLL_W-1:0]  b_broll;
  logic [COL_W-1:0]   b_col;
  logic [ROW_W-1:0]   b_row;
  logic               b_emit;
  logic               b_last;

  logic [STATE_W-1:0] rd_top;
  logic [STATE_W-1:0] rd_mid;

  cell_state_t        win [6];
  cell_state_t        nbrs [NBR_CNT];
  cell_state_t        rule_state;

  logic [MATCH_W-1:0] match_cnt;
  logic [MATCH_W-1:0] match_next;

  logic               in_fire;
  logic               out_free;
  logic               b_fire;
  logic               geom_write;

  assign out_free      = !m_axis_tvalid || m_axis_tready;
  assign b_fire        = b_valid && (!b_emit || out_free);
  assign s_axis_tready = !b_valid || b_fire;
  assign in_fire       = s_axis_tvalid && s_axis_tready;
  assign geom_write    = cfg_we && (cfg_index == REG_GRID_WIDTH ||
                                    cfg_index == REG_GRID_HEIGHT);

  // effective geometry, clamped to [3, MAX]
  always_comb begin
    gw_ext = WCMP_W'(grid_width);
    gh_ext = HCMP_W'(grid_height);
    if (gw_ext < WCMP_W'(MIN_DIM)) w_eff = WCMP_W'(MIN_DIM);
    else if (gw_ext > WCMP_W'(MAX_WIDTH)) w_eff = WCMP_W'(MAX_WIDTH);
    else w_eff = gw_ext;
    if (gh_ext < HCMP_W'(MIN_DIM)) h_eff = HCMP_W'(MIN_DIM);
    else if (gh_ext > HCMP_W'(MAX_HEIGHT)) h_eff = HCMP_W'(MAX_HEIGHT);
    else h_eff = gh_ext;
    col_last = COL_W'(w_eff - WCMP_W'(1));
    row_last = ROW_W'(h_eff - HCMP_W'(1));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      grid_width    <= GRID_WIDTH_RST;
      grid_height   <= GRID_HEIGHT_RST;
      counted_state <= COUNTED_STATE_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_GRID_WIDTH:    grid_width    <= cfg_data[GW_W-1:0];
        REG_GRID_HEIGHT:   grid_height   <= cfg_data[GH_W-1:0];
        REG_COUNTED_STATE: counted_state <= cfg_data[STATE_W-1:0];
        default: ;
      endcase
    end
  end

  // raster position of the next request
  always_ff @(posedge clk) begin
    if (rst || geom_write) begin
      col <= '0;
      row <= '0;
    end else if (in_fire) begin
      if (col == col_last) begin
        col <= '0;
        row <= (row == row_last) ? '0 : row + ROW_W'(1);
      end else begin
        col <= col + COL_W'(1);
      end
    end
  end

  // stage B: request waits here for its line store data
  always_ff @(posedge clk) begin
    if (rst) begin
      b_valid <= 1'b0;
    end else if (in_fire) begin
      b_valid <= 1'b1;
    end else if (b_fire) begin
      b_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      b_cur   <= cell_state_t'(s_axis_tdata[STATE_W-1:0]);
      b_iroll <= s_axis_tdata[STATE_W +: ROLL_W];
      b_broll <= s_axis_tdata[STATE_W+ROLL_W +: ROLL_W];
      b_col   <= col;
      b_row   <= row;
      b_emit  <= (col >= COL_W'(2)) && (row >= ROW_W'(2));
      b_last  <= (col == col_last) && (row == row_last);
    end
  end

  ffs_line_store #(
    .DEPTH  (MAX_WIDTH),
    .ADDR_W (COL_W)
  ) u_line_store (
    .clk       (clk),
    .rd_en     (in_fire),
    .rd_addr   (col),
    .rd_upper  (rd_top),
    .rd_middle (rd_mid),
    .wr_en     (b_fire),
    .wr_addr   (b_col),
    .wr_upper  (rd_mid),
    .wr_middle (b_cur)
  );

  // window: [0..2] column c-2 top/mid/bottom, [3..5] column c-1
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 6; i++) win[i] <= ST_HEALTHY;
    end else if (b_fire) begin
      win[0] <= win[3];
      win[1] <= win[4];
      win[2] <= win[5];
      win[3] <= cell_state_t'(rd_top);
      win[4] <= cell_state_t'(rd_mid);
      win[5] <= b_cur;
    end
  end

  always_comb begin
    nbrs[0] = win[0];
    nbrs[1] = win[1];
    nbrs[2] = win[2];
    nbrs[3] = win[3];
    nbrs[4] = win[5];
    nbrs[5] = cell_state_t'(rd_top);
    nbrs[6] = cell_state_t'(rd_mid);
    nbrs[7] = b_cur;
  end

  ffs_cell_rule u_cell_rule (
    .center       (win[4]),
    .nbrs         (nbrs),
    .ignite_roll  (b_iroll),
    .burnout_roll (b_broll),
    .new_state    (rule_state)
  );

  assign match_next = match_cnt +
                      MATCH_W'(STATE_W'(rule_state) == counted_state);

  always_ff @(posedge clk) begin
    if (rst || geom_write) begin
      match_cnt <= '0;
    end else if (b_fire && b_emit) begin
      match_cnt <= b_last ? '0 : match_next;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (b_fire && b_emit) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (b_fire && b_emit) begin
      m_axis_tdata <= M_TDATA_W'({match_next,
                                  ROW_OUT_W'(b_row - ROW_W'(1)),
                                  COL_OUT_W'(b_col - COL_W'(1)),
                                  STATE_W'(rule_state)});
      m_axis_tlast <= b_last;
    end
  end

endmodule
